[src/u2u_pkg.sv]
package u2u_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned COUNT_W = 16;

    localparam logic [COUNT_W-1:0] CAP_RESET = 16'd512;
    localparam logic [COUNT_W-1:0] UNIT_BYTES = 16'd2;

    localparam logic [7:0] MASK_TWO_LEAD   = 8'h1f;
    localparam logic [7:0] MASK_THREE_LEAD = 8'h0f;
    localparam logic [7:0] MASK_CONT       = 8'h3f;

    localparam logic [1:0] CONT_TAG      = 2'b10;
    localparam logic [2:0] TWO_LEAD_TAG  = 3'b110;
    localparam logic [3:0] THREE_LEAD_TAG = 4'b1110;

    localparam logic [1:0] NEED_ONE = 2'd1;
    localparam logic [1:0] NEED_TWO = 2'd2;

    // results caused by one input byte: an optional code unit, then an optional terminator
    typedef struct packed {
        logic              unit_valid;
        logic [UNIT_W-1:0] unit;
        logic              term_valid;
    } res_pair_t;

endpackage

[src/u2u_in_if.sv]
interface u2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, output in_byte, output byte_present, output end_of_text,
                    input ready);
    modport sink   (input valid, input in_byte, input byte_present, input end_of_text,
                    output ready);
endinterface

[src/u2u_out_if.sv]
interface u2u_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_terminator;
    logic        last_unit;

    modport source (output valid, output code_unit, output is_terminator, output last_unit,
                    input ready);
    modport sink   (input valid, input code_unit, input is_terminator, input last_unit,
                    output ready);
endinterface

[src/utf8_to_ucs2_decoder_core.sv]
// utf8 to ucs2 stream decoder
// in_ch carries one utf-8 byte per transfer with byte_present and end_of_text;
// an item with byte_present low and end_of_text high only closes the string.
// out_ch gives 16-bit code units; the closing zero unit has is_terminator and
// last_unit set and follows the final item of every string.
// cfg_wr_en / cfg_wr_data write the output capacity in bytes (reset 512); write
// it only while the block is idle.
// an accepted item is held in the input register and is decoded into the
// result register once that register is free; its first result is offered
// from the result register.
// throughput is one item per cycle while the receiver does not stall and each
// item gives at most one result; an item that gives a code unit and the
// terminator occupies the result register for two output transfers.
// when the receiver stalls, the result register holds and the input register
// takes one more item before in_ch.ready drops.
// reset clears the string state, the pending results and sets the capacity to
// its default.
module utf8_to_ucs2_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    u2u_in_if.sink      in_ch,
    u2u_out_if.source   out_ch
);
    import u2u_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       end_reg;
    logic       accept;
    logic       advance;
    logic       out_free;
    res_pair_t  pair;

    assign advance     = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || out_free;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg    <= in_ch.in_byte;
            present_reg <= in_ch.byte_present;
            end_reg     <= in_ch.end_of_text;
        end
    end

    u2u_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .step         (advance),
        .in_byte      (byte_reg),
        .byte_present (present_reg),
        .end_of_text  (end_reg),
        .pair         (pair)
    );

    u2u_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .pair   (pair),
        .free   (out_free),
        .out_ch (out_ch)
    );

endmodule

[src/u2u_decode.sv]
module u2u_decode
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [15:0]             cfg_wr_data,
    input  logic                    step,
    input  logic [7:0]              in_byte,
    input  logic                    byte_present,
    input  logic                    end_of_text,
    output u2u_pkg::res_pair_t      pair
);
    import u2u_pkg::*;

    logic [COUNT_W-1:0] cap_reg;
    logic [UNIT_W-1:0]  partial_reg, partial_next;
    logic [1:0]         need_reg, need_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;
    logic               full_reg, full_next;
    logic               lead;
    logic               at_cap;

    // capacity check uses the count before this byte; 17 bits so the add cannot wrap
    assign at_cap = ({1'b0, emitted_reg} + {1'b0, UNIT_BYTES}) >= {1'b0, cap_reg};

    always_comb
    begin
        partial_next    = partial_reg;
        need_next       = need_reg;
        emitted_next    = emitted_reg;
        full_next       = full_reg;
        lead            = 1'b0;
        pair.unit_valid = 1'b0;
        pair.unit       = '0;
        pair.term_valid = end_of_text;

        if (byte_present)
        begin
            if (need_reg != 2'd0)
            begin
                if (in_byte[7:6] == CONT_TAG)
                begin
                    partial_next = {partial_reg[UNIT_W-7:0], in_byte[5:0] & MASK_CONT[5:0]};
                    need_next    = need_reg - 2'd1;
                    if (need_next == 2'd0)
                    begin
                        pair.unit_valid = 1'b1;
                        pair.unit       = partial_next;
                        emitted_next    = emitted_reg + UNIT_BYTES;
                        partial_next    = '0;
                    end
                end
                else
                begin
                    // missing continuation: drop the pending form, retry as lead
                    partial_next = '0;
                    need_next    = 2'd0;
                    lead         = 1'b1;
                end
            end
            else
            begin
                lead = 1'b1;
            end
        end

        if (lead && !full_reg)
        begin
            if (at_cap)
            begin
                full_next = 1'b1;
            end
            else if (in_byte[7] == 1'b0)
            begin
                pair.unit_valid = 1'b1;
                pair.unit       = {8'd0, in_byte};
                emitted_next    = emitted_reg + UNIT_BYTES;
            end
            else if (in_byte[7:5] == TWO_LEAD_TAG)
            begin
                partial_next = {8'd0, in_byte & MASK_TWO_LEAD};
                need_next    = NEED_ONE;
            end
            else if (in_byte[7:4] == THREE_LEAD_TAG)
            begin
                partial_next = {8'd0, in_byte & MASK_THREE_LEAD};
                need_next    = NEED_TWO;
            end
        end

        if (end_of_text)
        begin
            partial_next = '0;
            need_next    = 2'd0;
            emitted_next = '0;
            full_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            partial_reg <= '0;
            need_reg    <= 2'd0;
            emitted_reg <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (step)
            begin
                partial_reg <= partial_next;
                need_reg    <= need_next;
                emitted_reg <= emitted_next;
                full_reg    <= full_next;
            end
        end
    end

endmodule

[src/u2u_out_stage.sv]
module u2u_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  u2u_pkg::res_pair_t pair,
    output logic               free,
    u2u_out_if.source          out_ch
);
    import u2u_pkg::*;

    logic              unit_pend_reg, unit_pend_next;
    logic              term_pend_reg, term_pend_next;
    logic [UNIT_W-1:0] unit_reg;
    logic              fire;

    assign out_ch.valid         = unit_pend_reg | term_pend_reg;
    assign out_ch.code_unit     = unit_pend_reg ? unit_reg : '0;
    assign out_ch.is_terminator = !unit_pend_reg;
    assign out_ch.last_unit     = !unit_pend_reg;

    assign fire = out_ch.valid && out_ch.ready;

    // empty now, or the last pending result leaves on this transfer
    assign free = !out_ch.valid || (fire && !(unit_pend_reg && term_pend_reg));

    always_comb
    begin
        unit_pend_next = unit_pend_reg;
        term_pend_next = term_pend_reg;
        if (load)
        begin
            unit_pend_next = pair.unit_valid;
            term_pend_next = pair.term_valid;
        end
        else if (fire)
        begin
            if (unit_pend_reg)
            begin
                unit_pend_next = 1'b0;
            end
            else
            begin
                term_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_pend_reg <= 1'b0;
            term_pend_reg <= 1'b0;
        end
        else
        begin
            unit_pend_reg <= unit_pend_next;
            term_pend_reg <= term_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            unit_reg <= pair.unit;
        end
    end

endmodule

[tb/utf8_to_ucs2_decoder_core_test.sv]
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_core_test;
    import u2u_pkg::*;

    localparam int IDLE_PCT      = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 800;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              term;
        logic              last;
    } ucs2_unit_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       eot;
    } utf8_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    u2u_in_if  in_ch();
    u2u_out_if out_ch();

    utf8_to_ucs2_decoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // decoder state mirrored by the testbench
    logic [COUNT_W-1:0] capacity_bytes;
    logic [COUNT_W-1:0] bytes_emitted;
    logic [UNIT_W-1:0]  gathered;
    logic [1:0]         conts_owed;
    logic               cap_reached;

    ucs2_unit_t expected_units[$];
    utf8_item_t string_items[$];
    ucs2_unit_t got_unit;
    ucs2_unit_t want_unit;
    int         errors;
    int         items_sent;
    int         idle_cycles;
    bit         steady;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void push_unit(logic [UNIT_W-1:0] value, logic term);
        ucs2_unit_t u;
        u.unit = value;
        u.term = term;
        u.last = term;
        expected_units.push_back(u);
        if (!term)
            bytes_emitted = bytes_emitted + UNIT_BYTES;
    endfunction

    function automatic void clear_form();
        gathered   = '0;
        conts_owed = '0;
    endfunction

    function automatic void decode_lead(logic [7:0] b);
        if (cap_reached)
        begin
        end
        else if ({1'b0, bytes_emitted} + {1'b0, UNIT_BYTES} >= {1'b0, capacity_bytes})
            cap_reached = 1'b1;
        else if (b[7] == 1'b0)
            push_unit({8'h00, b}, 1'b0);
        else if (b[7:5] == TWO_LEAD_TAG)
        begin
            gathered   = {8'h00, b & MASK_TWO_LEAD};
            conts_owed = NEED_ONE;
        end
        else if (b[7:4] == THREE_LEAD_TAG)
        begin
            gathered   = {8'h00, b & MASK_THREE_LEAD};
            conts_owed = NEED_TWO;
        end
    endfunction

    function automatic void decode_item(logic [7:0] b, logic present, logic eot);
        if (present)
        begin
            if (conts_owed != 2'd0)
            begin
                if (b[7:6] == CONT_TAG)
                begin
                    gathered   = (gathered << 6) | {8'h00, b & MASK_CONT};
                    conts_owed = conts_owed - 2'd1;
                    if (conts_owed == 2'd0)
                    begin
                        push_unit(gathered, 1'b0);
                        clear_form();
                    end
                end
                else
                begin
                    // broken form: the byte starts over in lead position
                    clear_form();
                    decode_lead(b);
                end
            end
            else
                decode_lead(b);
        end
        if (eot)
        begin
            push_unit('0, 1'b1);
            clear_form();
            bytes_emitted = '0;
            cap_reached   = 1'b0;
        end
    endfunction

    function automatic void add_item(logic [7:0] b, logic present, logic eot);
        utf8_item_t it;
        it.data    = b;
        it.present = present;
        it.eot     = eot;
        string_items.push_back(it);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic present, input logic eot);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.byte_present <= present;
        in_ch.end_of_text  <= eot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        decode_item(b, present, eot);
        if (present || eot)
            items_sent++;
    endtask

    task automatic send_string();
        utf8_item_t it;
        while (string_items.size() != 0)
        begin
            it = string_items.pop_front();
            send_item(it.data, it.present, it.eot);
        end
    endtask

    task automatic hold_idle(input int cycles);
        repeat (cycles)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_for_units();
        while (expected_units.size() != 0)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_capacity(input logic [15:0] value);
        wait_for_units();
        // items that give no unit may still be in flight
        hold_idle(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity_bytes = value;
    endtask

    task automatic test_char_forms();
        // well-formed units, extremes, overlong and surrogate values
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h7f, 1'b1, 1'b0);
        add_item(8'hdf, 1'b1, 1'b0);
        add_item(8'hbf, 1'b1, 1'b0);
        add_item(8'hef, 1'b1, 1'b0);
        add_item(8'hbf, 1'b1, 1'b0);
        add_item(8'hbf, 1'b1, 1'b0);
        add_item(8'hed, 1'b1, 1'b0);
        add_item(8'ha0, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'hc0, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'h5a, 1'b0, 1'b1);
        send_string();
        // stray continuation, bad leads, broken forms, empty item, cut-off end
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'hf8, 1'b1, 1'b0);
        add_item(8'hf0, 1'b1, 1'b0);
        add_item(8'hc3, 1'b1, 1'b0);
        add_item(8'h41, 1'b1, 1'b0);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'he2, 1'b1, 1'b0);
        add_item(8'hc3, 1'b1, 1'b0);
        add_item(8'ha9, 1'b1, 1'b0);
        add_item(8'he2, 1'b1, 1'b0);
        add_item(8'h82, 1'b1, 1'b1);
        send_string();
    endtask

    task automatic test_capacity_limit();
        set_capacity(16'd0);
        add_item(8'h41, 1'b1, 1'b1);
        send_string();
        // a form started just below the limit still completes
        set_capacity(16'd6);
        add_item(8'h41, 1'b1, 1'b0);
        add_item(8'he2, 1'b1, 1'b0);
        add_item(8'h82, 1'b1, 1'b0);
        add_item(8'hac, 1'b1, 1'b0);
        add_item(8'h42, 1'b1, 1'b0);
        add_item(8'hc3, 1'b1, 1'b1);
        send_string();
        set_capacity(CAP_RESET);
    endtask

    function automatic logic [15:0] pick_capacity();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return 16'($urandom_range(5));
            1:       return 16'hffff;
            2:       return CAP_RESET;
            3:       return 16'($urandom_range(65535));
            default: return 16'($urandom_range(96, 8));
        endcase
    endfunction

    task automatic build_random_string();
        int         chars;
        int         kind;
        logic [7:0] r;
        logic [7:0] s;
        logic [7:0] t;
        chars = $urandom_range(24);
        repeat (chars)
        begin
            kind = $urandom_range(99);
            r = 8'($urandom);
            s = 8'($urandom);
            t = 8'($urandom);
            if (kind < 40)
                add_item({1'b0, r[6:0]}, 1'b1, 1'b0);
            else if (kind < 62)
            begin
                add_item({TWO_LEAD_TAG, r[4:0]}, 1'b1, 1'b0);
                add_item({CONT_TAG, s[5:0]}, 1'b1, 1'b0);
            end
            else if (kind < 82)
            begin
                add_item({THREE_LEAD_TAG, r[3:0]}, 1'b1, 1'b0);
                add_item({CONT_TAG, s[5:0]}, 1'b1, 1'b0);
                add_item({CONT_TAG, t[5:0]}, 1'b1, 1'b0);
            end
            else if (kind < 86)
                add_item(r, 1'b1, 1'b0);
            else if (kind < 89)
                add_item({CONT_TAG, r[5:0]}, 1'b1, 1'b0);
            else if (kind < 92)
                add_item({4'hf, r[3:0]}, 1'b1, 1'b0);
            else if (kind < 94)
                add_item({TWO_LEAD_TAG, r[4:0]}, 1'b1, 1'b0);
            else if (kind < 96)
            begin
                add_item({THREE_LEAD_TAG, r[3:0]}, 1'b1, 1'b0);
                add_item({CONT_TAG, s[5:0]}, 1'b1, 1'b0);
            end
            else
                add_item(r, 1'b0, 1'b0);
        end
        if (string_items.size() != 0 && $urandom_range(1) == 1)
            string_items[string_items.size() - 1].eot = 1'b1;
        else
            add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_random_strings();
        int strings;
        int first_count;
        strings     = 0;
        first_count = items_sent;
        while (items_sent - first_count < RANDOM_ITEMS)
        begin
            if (strings % 4 == 0)
                set_capacity(pick_capacity());
            steady = (strings >= 12 && strings < 24);
            build_random_string();
            send_string();
            strings++;
        end
        steady = 1'b0;
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_unit.unit = out_ch.code_unit;
            got_unit.term = out_ch.is_terminator;
            got_unit.last = out_ch.last_unit;
            if (expected_units.size() == 0)
            begin
                $display("%0t: unexpected transfer, code_unit %h is_terminator %b last_unit %b",
                         $time, got_unit.unit, got_unit.term, got_unit.last);
                errors++;
            end
            else
            begin
                want_unit = expected_units.pop_front();
                if (got_unit.unit !== want_unit.unit)
                begin
                    $display("%0t: code_unit expected %h got %h",
                             $time, want_unit.unit, got_unit.unit);
                    errors++;
                end
                if (got_unit.term !== want_unit.term)
                begin
                    $display("%0t: is_terminator expected %b got %b",
                             $time, want_unit.term, got_unit.term);
                    errors++;
                end
                if (got_unit.last !== want_unit.last)
                begin
                    $display("%0t: last_unit expected %b got %b",
                             $time, want_unit.last, got_unit.last);
                    errors++;
                end
            end
        end
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d units outstanding",
                     $time, STALL_LIMIT, expected_units.size());
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_text  = 1'b0;
        out_ch.ready       = 1'b0;
        errors             = 0;
        items_sent         = 0;
        idle_cycles        = 0;
        steady             = 1'b0;
        capacity_bytes     = CAP_RESET;
        bytes_emitted      = '0;
        cap_reached        = 1'b0;
        clear_form();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_char_forms();
        test_capacity_limit();
        test_random_strings();

        wait_for_units();
        hold_idle(2 * SETTLE_CYCLES);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
